>>> design/kdrm_pkg.sv
// ----------------------------------------------------------------------------
// kdrm_pkg
// Shared types and constants of the keypad debounce, repeat and modifier core.
// ----------------------------------------------------------------------------
package kdrm_pkg;

  // Widths of the fixed fields.
  localparam int TICK_W  = 32;
  localparam int KEYID_W = 6;
  localparam int FLAG_W  = 5;
  localparam int CSET_W  = 2;
  localparam int CFG_A_W = 3;

  // Modifier flag bit positions.
  localparam int FLAG_SYM = 0;
  localparam int FLAG_ALT = 1;
  localparam int FLAG_LSH = 2;
  localparam int FLAG_RSH = 3;
  localparam int FLAG_MIC = 4;

  // Character set codes.
  localparam logic [CSET_W-1:0] CSET_LOWER  = 2'd0;
  localparam logic [CSET_W-1:0] CSET_BASE   = 2'd1;
  localparam logic [CSET_W-1:0] CSET_SYMBOL = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_A_W-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_REPEAT   = 3'd1,
    CFG_SYM      = 3'd2,
    CFG_ALT      = 3'd3,
    CFG_LSHIFT   = 3'd4,
    CFG_RSHIFT   = 3'd5,
    CFG_MIC      = 3'd6
  } kdrm_cfg_idx_t;

  // One entry of the per-key state memory.
  typedef struct packed {
    logic              latch;
    logic [TICK_W-1:0] deadline;
  } kdrm_entry_t;

  localparam int ENTRY_W = $bits(kdrm_entry_t);

  // Configuration seen by the step logic.
  typedef struct packed {
    logic [TICK_W-1:0]  debounce;
    logic [TICK_W-1:0]  rpt;
    logic [KEYID_W-1:0] sym_key;
    logic [KEYID_W-1:0] alt_key;
    logic [KEYID_W-1:0] lsh_key;
    logic [KEYID_W-1:0] rsh_key;
    logic [KEYID_W-1:0] mic_key;
  } kdrm_cfg_t;

  // Decision of the step logic for one sample.
  typedef struct packed {
    logic              wr_en;
    kdrm_entry_t       entry;
    logic [FLAG_W-1:0] flags;
    logic              emit;
    logic [CSET_W-1:0] char_set;
  } kdrm_step_t;

endpackage

>>> design/kdrm_ram.sv
// ----------------------------------------------------------------------------
// kdrm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kdrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; a read of an address written in the same cycle returns old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> design/kdrm_step.sv
// ----------------------------------------------------------------------------
// kdrm_step
// Per-sample decision: debounce, auto-repeat and modifier flag update for one
// key entry.
// ----------------------------------------------------------------------------
module kdrm_step
  import kdrm_pkg::*;
(
  input  logic               active,
  input  logic               pressed,
  input  logic [TICK_W-1:0]  now_tick,
  input  logic [KEYID_W-1:0] key_id,
  input  kdrm_entry_t        entry,
  input  logic [FLAG_W-1:0]  flags,
  input  kdrm_cfg_t          cfg,
  output kdrm_step_t         res
);

  logic              due;
  logic              rel_hit;
  logic              press_hit;
  logic [FLAG_W-1:0] rel_mask;
  logic [FLAG_W-1:0] press_mask;
  logic [TICK_W-1:0] offset;

  // Modifier decode, first match in the order sym, alt, shifts, mic.
  always_comb begin
    rel_mask   = '0;
    press_mask = '0;
    if (key_id == cfg.sym_key) begin
      rel_mask[FLAG_SYM] = 1'b1;
    end else if (key_id == cfg.alt_key) begin
      rel_mask[FLAG_ALT] = 1'b1;
    end else if (key_id == cfg.lsh_key) begin
      rel_mask[FLAG_LSH] = 1'b1;
    end else if (key_id == cfg.rsh_key) begin
      rel_mask[FLAG_RSH] = 1'b1;
    end else if (key_id == cfg.mic_key) begin
      rel_mask[FLAG_MIC] = 1'b1;
    end
    // Mic acts as an ordinary key while sym is held.
    press_mask = rel_mask;
    if (flags[FLAG_SYM]) begin
      press_mask[FLAG_MIC] = 1'b0;
    end
  end

  assign due       = (now_tick >= entry.deadline);
  assign rel_hit   = active & ~pressed & entry.latch;
  assign press_hit = active & pressed & due;
  assign offset    = (pressed & entry.latch) ? cfg.rpt : cfg.debounce;

  // New entry, flags and result.
  always_comb begin
    res                = '0;
    res.flags          = flags;
    res.entry.latch    = pressed;
    res.entry.deadline = now_tick + offset;
    res.wr_en          = rel_hit | press_hit;
    if (rel_hit) begin
      res.flags = flags & ~rel_mask;
    end else if (press_hit) begin
      if (press_mask != '0) begin
        res.flags = flags | press_mask;
      end else begin
        res.emit = 1'b1;
      end
    end
    if (flags[FLAG_SYM]) begin
      res.char_set = CSET_SYMBOL;
    end else if (flags[FLAG_LSH] | flags[FLAG_RSH]) begin
      res.char_set = CSET_BASE;
    end else begin
      res.char_set = CSET_LOWER;
    end
  end

endmodule

>>> design/keypad_debounce_repeat_modifiers_core.sv
// ----------------------------------------------------------------------------
// keypad_debounce_repeat_modifiers_core
// Keypad sample debouncer with auto-repeat and modifier flag tracking.
//
//   Channel  Direction  Payload (lowest bit up)
//   in_      slave      key_col[2:0], key_row[5:3], key_pressed[6], now_tick[38:7]
//   out_     master     out_col[2:0], out_row[5:3], char_set[7:6], modifier_mask[12:8]
//   cfg_     write      register index, 32-bit data
//
// One sample is taken per cycle, unless a stalled output holds a sample that
// must emit; it holds only such samples. Stages: key state memory read, then
// decision and write-back, with the result in the output register. A sample
// that hits the key written the cycle before uses the forwarded entry. Reset
// clears all key valid bits at once, so there is no clearing pass.
// ----------------------------------------------------------------------------
module keypad_debounce_repeat_modifiers_core
  import kdrm_pkg::*;
#(
  parameter int NUM_COLS = 8,
  parameter int NUM_ROWS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // Fields: key_col, key_row, key_pressed, now_tick
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,
  // Fields: out_col, out_row, char_set, modifier_mask
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [TICK_W-1:0]  cfg_wdata
);

  localparam int KEYS = NUM_COLS * NUM_ROWS;
  localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;

  // Configuration registers.
  kdrm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce <= TICK_W'(20);
      cfg_r.rpt      <= TICK_W'(100);
      cfg_r.sym_key  <= KEYID_W'(0);
      cfg_r.alt_key  <= KEYID_W'(1);
      cfg_r.lsh_key  <= KEYID_W'(2);
      cfg_r.rsh_key  <= KEYID_W'(3);
      cfg_r.mic_key  <= KEYID_W'(4);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEBOUNCE: cfg_r.debounce <= cfg_wdata;
        CFG_REPEAT:   cfg_r.rpt      <= cfg_wdata;
        CFG_SYM:      cfg_r.sym_key  <= cfg_wdata[KEYID_W-1:0];
        CFG_ALT:      cfg_r.alt_key  <= cfg_wdata[KEYID_W-1:0];
        CFG_LSHIFT:   cfg_r.lsh_key  <= cfg_wdata[KEYID_W-1:0];
        CFG_RSHIFT:   cfg_r.rsh_key  <= cfg_wdata[KEYID_W-1:0];
        CFG_MIC:      cfg_r.mic_key  <= cfg_wdata[KEYID_W-1:0];
        default: ;
      endcase
    end
  end

  // Input unpacking and key index.
  logic [2:0]         in_col;
  logic [2:0]         in_row;
  logic               in_in_grid;
  logic [KEYID_W-1:0] in_kid;
  logic               in_fire;

  assign in_col     = in_tdata[2:0];
  assign in_row     = in_tdata[5:3];
  assign in_in_grid = ({1'b0, in_col} < 4'(NUM_COLS)) && ({1'b0, in_row} < 4'(NUM_ROWS));
  assign in_kid     = KEYID_W'(in_col) * KEYID_W'(NUM_ROWS) + KEYID_W'(in_row);
  assign in_fire    = in_tvalid & in_tready;

  // Stage 1 registers: the sample whose entry is being read.
  logic               s1_vld_r;
  logic               s1_grid_r;
  logic [2:0]         s1_col_r;
  logic [2:0]         s1_row_r;
  logic               s1_pressed_r;
  logic [TICK_W-1:0]  s1_now_r;
  logic [KEYID_W-1:0] s1_kid_r;
  logic [KW-1:0]      s1_addr;
  logic               s1_fire;

  // Key state memory, valid bits and forwarding of the latest write.
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KEYS-1:0]    key_vld_r;
  logic               wr_vld_r;
  logic [KW-1:0]      wr_addr_r;
  kdrm_entry_t        wr_data_r;
  kdrm_entry_t        cur_entry;
  logic [FLAG_W-1:0]  flags_r;
  kdrm_step_t         res;
  logic               wr_fire;

  assign s1_addr = s1_kid_r[KW-1:0];
  assign wr_fire = s1_fire & res.wr_en;

  kdrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (KEYS),
    .AW    (KW)
  ) u_key_ram (
    .clk   (clk),
    .we    (wr_fire),
    .waddr (s1_addr),
    .wdata (res.entry),
    .re    (in_fire),
    .raddr (in_kid[KW-1:0]),
    .rdata (ram_rdata)
  );

  // Entry seen by stage 1: forwarded write, memory data or reset value.
  always_comb begin
    if (wr_vld_r && (wr_addr_r == s1_addr)) begin
      cur_entry = wr_data_r;
    end else if (key_vld_r[s1_addr]) begin
      cur_entry = kdrm_entry_t'(ram_rdata);
    end else begin
      cur_entry = '0;
    end
  end

  kdrm_step u_step (
    .active   (s1_grid_r),
    .pressed  (s1_pressed_r),
    .now_tick (s1_now_r),
    .key_id   (s1_kid_r),
    .entry    (cur_entry),
    .flags    (flags_r),
    .cfg      (cfg_r),
    .res      (res)
  );

  // Handshake: stage 1 moves on unless it must emit into a full output.
  logic out_vld_r;

  assign s1_fire   = s1_vld_r & (~res.emit | ~out_vld_r | out_tready);
  assign in_tready = ~s1_vld_r | s1_fire;

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_grid_r    <= in_in_grid;
      s1_col_r     <= in_col;
      s1_row_r     <= in_row;
      s1_pressed_r <= in_tdata[6];
      s1_now_r     <= in_tdata[38:7];
      s1_kid_r     <= in_kid;
    end
  end

  // Control state: stage valid, key valid bits, flags, forwarding tag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      key_vld_r <= '0;
      flags_r   <= '0;
      wr_vld_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        flags_r <= res.flags;
      end
      if (wr_fire) begin
        key_vld_r[s1_addr] <= 1'b1;
        wr_vld_r           <= 1'b1;
      end
    end
  end

  // Forwarded write data.
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      wr_addr_r <= s1_addr;
      wr_data_r <= res.entry;
    end
  end

  // Output register.
  logic [15:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire & res.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire & res.emit) begin
      out_data_r <= {3'b000, res.flags, res.char_set, s1_row_r, s1_col_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

>>> bench/kdrm_key_checker.sv
// ----------------------------------------------------------------------------
// kdrm_key_checker
// Watches the sample, character and register ports of the keypad core. It
// keeps its own copy of the per-key latch and deadline state and the modifier
// flags, and works out the character each accepted sample should emit. Each
// character transfer is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module kdrm_key_checker
  import kdrm_pkg::*;
#(
  parameter int NUM_COLS = 8,
  parameter int NUM_ROWS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  // Fields: key_col, key_row, key_pressed, now_tick
  input  logic [39:0]        in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  // Fields: out_col, out_row, char_set, modifier_mask
  input  logic [15:0]        out_tdata,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [TICK_W-1:0]  cfg_wdata,
  output int                 fail_count,
  output int                 pending_chars
);

  localparam int KEY_COUNT = 64;

  typedef struct packed {
    logic [2:0]        col;
    logic [2:0]        row;
    logic [CSET_W-1:0] char_set;
    logic [FLAG_W-1:0] mask;
  } key_char_t;

  key_char_t          expected_chars[$];
  logic [TICK_W-1:0]  debounce_ticks;
  logic [TICK_W-1:0]  repeat_ticks;
  logic [KEYID_W-1:0] modifier_key [FLAG_W];
  logic               key_held [KEY_COUNT];
  logic [TICK_W-1:0]  key_deadline [KEY_COUNT];
  logic [FLAG_W-1:0]  modifier_flags;
  int                 errors = 0;

  // State and registers as they come out of reset.
  task automatic restore_defaults();
    debounce_ticks = 20;
    repeat_ticks   = 100;
    for (int f = FLAG_SYM; f <= FLAG_MIC; f++) begin
      modifier_key[f] = KEYID_W'(f);
    end
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_held[k]     = 1'b0;
      key_deadline[k] = '0;
    end
    modifier_flags = '0;
    expected_chars.delete();
  endtask

  // Flag owned by key k. The first matching modifier wins. On a press the
  // mic key only counts as a modifier while the sym flag is clear.
  function automatic logic [FLAG_W-1:0] modifier_bit(input logic [KEYID_W-1:0] k,
                                                     input logic on_press);
    logic [FLAG_W-1:0] one_hot;
    one_hot = '0;
    for (int f = FLAG_SYM; f <= FLAG_MIC; f++) begin
      if (modifier_key[f] == k &&
          !(on_press && f == FLAG_MIC && modifier_flags[FLAG_SYM])) begin
        one_hot[f] = 1'b1;
        return one_hot;
      end
    end
    return one_hot;
  endfunction

  // Debounce, repeat and modifier decision for one sample.
  task automatic predict_sample(input logic [2:0] col, input logic [2:0] row,
                                input logic pressed, input logic [TICK_W-1:0] now);
    logic [KEYID_W-1:0] k;
    logic [FLAG_W-1:0]  f;
    key_char_t          ch;
    if (col >= NUM_COLS || row >= NUM_ROWS) return;
    k = KEYID_W'(col * NUM_ROWS + row);
    if (!pressed) begin
      // A release counts only for a latched key, and it counts at once.
      if (key_held[k]) begin
        key_deadline[k] = now + debounce_ticks;
        key_held[k]     = 1'b0;
        modifier_flags  = modifier_flags & ~modifier_bit(k, 1'b0);
      end
    end else if (now >= key_deadline[k]) begin
      // A first press or a repeat of a held key.
      key_deadline[k] = now + (key_held[k] ? repeat_ticks : debounce_ticks);
      key_held[k]     = 1'b1;
      f = modifier_bit(k, 1'b1);
      if (f != '0) begin
        modifier_flags = modifier_flags | f;
      end else begin
        ch.col  = col;
        ch.row  = row;
        ch.mask = modifier_flags;
        if (modifier_flags[FLAG_SYM]) begin
          ch.char_set = CSET_SYMBOL;
        end else if (modifier_flags[FLAG_LSH] || modifier_flags[FLAG_RSH]) begin
          ch.char_set = CSET_BASE;
        end else begin
          ch.char_set = CSET_LOWER;
        end
        expected_chars.push_back(ch);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // One character transfer against the oldest expectation.
  task automatic check_char(input logic [15:0] data);
    key_char_t want;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected character: expected none, %s %0d row %0d set %0d mask %05b",
               $time, "actual col", data[2:0], data[5:3], data[7:6], data[12:8]);
      errors++;
      return;
    end
    want = expected_chars.pop_front();
    check_field("out_col", want.col, data[2:0]);
    check_field("out_row", want.row, data[5:3]);
    check_field("char_set", want.char_set, data[7:6]);
    check_field("modifier_mask", want.mask, data[12:8]);
  endtask

  // Results are taken before samples of the same edge: a sample accepted now
  // cannot leave the core in the same cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      restore_defaults();
    end else begin
      if (out_tvalid && out_tready) check_char(out_tdata);
      if (cfg_we) begin
        case (kdrm_cfg_idx_t'(cfg_addr))
          CFG_DEBOUNCE: debounce_ticks = cfg_wdata;
          CFG_REPEAT:   repeat_ticks   = cfg_wdata;
          CFG_SYM:      modifier_key[FLAG_SYM] = cfg_wdata[KEYID_W-1:0];
          CFG_ALT:      modifier_key[FLAG_ALT] = cfg_wdata[KEYID_W-1:0];
          CFG_LSHIFT:   modifier_key[FLAG_LSH] = cfg_wdata[KEYID_W-1:0];
          CFG_RSHIFT:   modifier_key[FLAG_RSH] = cfg_wdata[KEYID_W-1:0];
          CFG_MIC:      modifier_key[FLAG_MIC] = cfg_wdata[KEYID_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_sample(in_tdata[2:0], in_tdata[5:3], in_tdata[6], in_tdata[38:7]);
      end
    end
    fail_count    <= errors;
    pending_chars <= expected_chars.size();
  end

endmodule

>>> bench/keypad_debounce_repeat_modifiers_core_test.sv
// ----------------------------------------------------------------------------
// keypad_debounce_repeat_modifiers_core_test
// Drives key samples and register writes into the keypad core. A short
// directed run covers first presses, ignored bounces, repeats, releases,
// every modifier, mic while sym is held and deadline wrap. Random phases
// then play press, hold and release sequences under several register
// settings, with bursty input and a stalling output. The checker beside the
// core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module keypad_debounce_repeat_modifiers_core_test;
  import kdrm_pkg::*;

  localparam int DIRECTED_ITEMS = 24;
  localparam int PHASE_ITEMS    = 270;
  localparam int PHASES         = 6;
  localparam int SETTLE_CYCLES  = 8;
  localparam int IDLE_LIMIT     = 3000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [39:0]        in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [15:0]        out_tdata;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [TICK_W-1:0]  cfg_wdata;

  int                 fail_count;
  int                 pending_chars;
  int                 idle_cycles = 0;
  int                 items_sent;
  int                 burst_left;
  bit                 gaps_on;
  logic [TICK_W-1:0]  tick_now;
  logic [TICK_W-1:0]  reg_value [7];
  logic [KEYID_W-1:0] modifier_key [FLAG_W];

  keypad_debounce_repeat_modifiers_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  kdrm_key_checker key_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_chars (pending_chars)
  );

  always #4 clk = ~clk;

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("keypad_debounce_repeat_modifiers_core verification failed");
      $finish;
    end
  end

  // Result side: runs of steady or random ready, and now and then a long
  // hold-off so that the core backs up into its input.
  initial begin
    int unsigned run;
    int unsigned mode;
    run = 0;
    forever begin
      run++;
      if (run % 12 == 3) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(60, 120)) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        repeat ($urandom_range(5, 40)) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [TICK_W-1:0] next_tick(input int unsigned step_max);
    tick_now = tick_now + $urandom_range(0, step_max);
    return tick_now;
  endfunction

  // One sample transfer; random-length bursts, with idle gaps if gaps_on.
  task automatic send_key(input logic [2:0] col, input logic [2:0] row,
                          input logic pressed, input logic [TICK_W-1:0] tick);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if (gaps_on) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, tick, pressed, row, col};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stop sending until every expected character is out, then let samples
  // that emit nothing leave the pipeline too. The first edge lets the
  // checker count the sample taken at the last edge.
  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [KEYID_W-1:0] key;
    logic [KEYID_W-1:0] held_mod;
    bit                 with_mod;
    int unsigned        step_max;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_DEBOUNCE;
    cfg_wdata <= '0;
    items_sent = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    tick_now   = '0;
    for (int f = FLAG_SYM; f <= FLAG_MIC; f++) modifier_key[f] = KEYID_W'(f);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed run with the reset settings: debounce 20, repeat 100,
    // modifiers on keys 0 to 4 of column 0.
    send_key(3'd1, 3'd1, 1'b1, 32'd0);            // first press, lowercase
    send_key(3'd1, 3'd1, 1'b1, 32'd5);            // bounce before deadline
    send_key(3'd1, 3'd1, 1'b1, 32'd20);           // held key repeats
    send_key(3'd1, 3'd1, 1'b0, 32'd21);           // release at once
    send_key(3'd1, 3'd1, 1'b0, 32'd22);           // release of free key
    send_key(3'd0, 3'd2, 1'b1, 32'd30);           // left shift
    send_key(3'd1, 3'd1, 1'b1, 32'd45);           // base set
    send_key(3'd0, 3'd0, 1'b1, 32'd50);           // sym
    send_key(3'd0, 3'd4, 1'b1, 32'd51);           // mic under sym emits
    send_key(3'd0, 3'd4, 1'b0, 32'd52);
    send_key(3'd0, 3'd0, 1'b0, 32'd53);
    send_key(3'd0, 3'd4, 1'b1, 32'd80);           // mic as a modifier
    send_key(3'd0, 3'd4, 1'b1, 32'd180);          // modifier repeat, silent
    send_key(3'd0, 3'd1, 1'b1, 32'd181);          // alt
    send_key(3'd0, 3'd3, 1'b1, 32'd182);          // right shift
    send_key(3'd7, 3'd7, 1'b1, 32'd200);          // highest key, four flags
    send_key(3'd0, 3'd1, 1'b0, 32'd201);
    send_key(3'd0, 3'd3, 1'b0, 32'd202);
    send_key(3'd0, 3'd2, 1'b0, 32'd203);
    send_key(3'd0, 3'd4, 1'b0, 32'd204);
    send_key(3'd7, 3'd7, 1'b1, 32'd205);          // still inside debounce
    send_key(3'd7, 3'd0, 1'b1, 32'hFFFF_FFF0);    // deadline wraps past zero
    send_key(3'd7, 3'd0, 1'b1, 32'hFFFF_FFF5);
    send_key(3'd7, 3'd0, 1'b0, 32'hFFFF_FFF6);
    tick_now = 32'd300;

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      // Order: debounce, repeat, sym, alt, left shift, right shift, mic.
      case (phase)
        0: reg_value = '{32'd0, 32'd0, 32'd63, 32'd62, 32'd0, 32'd7, 32'd8};
        1: reg_value = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 32'd5, 32'd5, 32'd5, 32'd5};
        2: reg_value = '{32'd3, 32'd12, 32'd9, 32'd10, 32'd11, 32'd12, 32'd9};
        3: reg_value = '{$urandom_range(0, 60), $urandom_range(0, 200),
                         $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 63)};
        4: reg_value = '{$urandom_range(0, 60), $urandom_range(0, 200),
                         $urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(0, 7)};
        default: reg_value = '{32'd20, 32'd100, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4};
      endcase
      for (int i = CFG_DEBOUNCE; i <= CFG_MIC; i++) begin
        cfg_we    <= 1'b1;
        cfg_addr  <= kdrm_cfg_idx_t'(i);
        cfg_wdata <= reg_value[i];
        @(posedge clk);
      end
      cfg_we <= 1'b0;
      for (int f = FLAG_SYM; f <= FLAG_MIC; f++) begin
        modifier_key[f] = reg_value[CFG_SYM + f][KEYID_W-1:0];
      end
      gaps_on = (phase != 1);
      if (phase == PHASES - 1) tick_now = 32'hFFFF_FF00;

      while (items_sent < DIRECTED_ITEMS + PHASE_ITEMS * (phase + 1)) begin
        key = $urandom_range(0, 63);
        if ($urandom_range(0, 3) == 0) begin
          // Loose sample, sometimes at an unrelated tick.
          send_key(key[5:3], key[2:0], 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 3) == 0) ? $urandom : next_tick(40));
        end else begin
          // Press, hold and release, maybe under a held modifier.
          case ($urandom_range(0, 3))
            0:       step_max = 0;
            1:       step_max = 8;
            2:       step_max = 40;
            default: step_max = 150;
          endcase
          with_mod = ($urandom_range(0, 2) == 0);
          held_mod = modifier_key[$urandom_range(FLAG_SYM, FLAG_MIC)];
          if (with_mod) send_key(held_mod[5:3], held_mod[2:0], 1'b1, next_tick(step_max));
          repeat ($urandom_range(1, 6)) begin
            send_key(key[5:3], key[2:0], 1'b1, next_tick(step_max));
          end
          send_key(key[5:3], key[2:0], 1'b0, next_tick(step_max));
          if (with_mod) send_key(held_mod[5:3], held_mod[2:0], 1'b0, next_tick(step_max));
        end
      end
    end

    drain();
    if (fail_count == 0 && pending_chars == 0) begin
      $display("keypad_debounce_repeat_modifiers_core verification clean");
    end else begin
      $display("keypad_debounce_repeat_modifiers_core verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/kdrm_pkg.sv
design/kdrm_ram.sv
design/kdrm_step.sv
design/keypad_debounce_repeat_modifiers_core.sv
bench/kdrm_key_checker.sv
bench/keypad_debounce_repeat_modifiers_core_test.sv
